FILE: rtl/ctkd_pkg.sv
// Shared types, constants and the fixed-point filter step of the touch key detector.
// Used by every module of the block but ctkd_ram; depends on nothing.
package ctkd_pkg;

    // field widths
    localparam int SAMPLE_W   = 10;
    localparam int FRAC_W     = 8;
    localparam int LEVEL_W    = SAMPLE_W + FRAC_W;
    localparam int COEFF_W    = 16;
    localparam int FACTOR_W   = 16;
    localparam int COUNT_W    = 8;
    localparam int THR_W      = LEVEL_W + FACTOR_W + 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 8;

    // reset values of the configuration registers
    localparam logic [COEFF_W-1:0]  SLOW_COEFF_RST     = 16'd31654;
    localparam logic [COEFF_W-1:0]  FAST_COEFF_RST     = 16'd58655;
    localparam logic [FACTOR_W-1:0] PRESS_FACTOR_RST   = 16'd459;
    localparam logic [FACTOR_W-1:0] RELEASE_FACTOR_RST = 16'd393;
    localparam logic [COUNT_W-1:0]  STARTUP_COUNT_RST  = 8'd32;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SLOW_COEFF     = 3'd0,
        REG_FAST_COEFF     = 3'd1,
        REG_PRESS_FACTOR   = 3'd2,
        REG_RELEASE_FACTOR = 3'd3,
        REG_STARTUP_COUNT  = 3'd4
    } cfg_reg_t;

    // one memory word: both filter levels of a key, unsigned Q10.8
    typedef struct packed {
        logic [LEVEL_W-1:0] slow;
        logic [LEVEL_W-1:0] fast;
    } level_pair_t;

    // decide stage status seen by the update stage
    typedef struct packed {
        logic valid;   // decide stage holds a word
        logic stay;    // that word fires a press, pointer holds
        logic move;    // that word leaves this cycle and is written back
        logic ready;   // decide stage can take a word this cycle
    } det_status_t;

    // result word, last field in the lowest bits
    typedef struct packed {
        logic [2:0] pad;
        logic [1:0] next_key;
        logic [1:0] pressed_key;
        logic       press_event;
    } out_word_t;

    // level + floor(coeff * (target - level) / 2^16), one multiply
    function automatic logic [LEVEL_W-1:0] iir_step(
        input logic [LEVEL_W-1:0] level,
        input logic [LEVEL_W-1:0] target,
        input logic [COEFF_W-1:0] coeff
    );
        logic signed [LEVEL_W:0]           diff;
        logic signed [LEVEL_W+COEFF_W+1:0] prod;
        logic signed [LEVEL_W:0]           step;
        logic        [LEVEL_W:0]           sum;
        diff = $signed({1'b0, target}) - $signed({1'b0, level});
        prod = diff * $signed({1'b0, coeff});
        step = prod[LEVEL_W+COEFF_W:COEFF_W];
        sum  = {1'b0, level} + $unsigned(step);
        return sum[LEVEL_W-1:0];
    endfunction

endpackage

FILE: rtl/ctkd_ram.sv
// Generic single-write, single-read memory with registered read data.
// Stand-alone; no package needed.
module ctkd_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 4,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/ctkd_filter.sv
// Slow and fast IIR update of one key's level pair toward a new sample.
// Depends on ctkd_pkg for the level type and the filter step.
module ctkd_filter
    import ctkd_pkg::*;
(
    input  level_pair_t         levels,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic [COEFF_W-1:0]  slow_coeff,
    input  logic [COEFF_W-1:0]  fast_coeff,
    output level_pair_t         updated
);

    logic [LEVEL_W-1:0] target;

    // pull both levels toward the sample in Q10.8
    always_comb
    begin
        target       = {sample, FRAC_W'(0)};
        updated.slow = iir_step(levels.slow, target, slow_coeff);
        updated.fast = iir_step(levels.fast, target, fast_coeff);
    end

endmodule

FILE: rtl/ctkd_detect.sv
// Decide stage: press and release thresholds, per-key latch bits, result register.
// Depends on ctkd_pkg for the level, status and result word types.
module ctkd_detect
    import ctkd_pkg::*;
#(
    parameter int NUM_KEYS = 4,
    parameter int KW       = 2
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  logic [KW-1:0]         in_key,
    input  logic [KW-1:0]         in_adv_key,
    input  level_pair_t           in_levels,
    input  logic                  in_detect,
    input  logic [FACTOR_W-1:0]   press_factor,
    input  logic [FACTOR_W-1:0]   release_factor,
    output det_status_t           status,
    output logic [KW-1:0]         key,
    output logic [KW-1:0]         final_key,
    output level_pair_t           levels,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // press_event, pressed_key[1:0], next_key[1:0]
);

    logic                  c_valid_reg;
    logic [KW-1:0]         c_key_reg;
    logic [KW-1:0]         c_adv_reg;
    level_pair_t           c_levels_reg;
    logic                  c_detect_reg;
    logic [NUM_KEYS-1:0]   latched_reg;
    logic                  o_valid_reg;
    out_word_t             o_data_reg;

    logic signed [LEVEL_W:0]     lvl_diff;
    logic signed [THR_W-1:0]     diff_scaled;
    logic [LEVEL_W+FACTOR_W-1:0] press_thr;
    logic [LEVEL_W+FACTOR_W-1:0] rel_thr;
    logic                        press_hit;
    logic                        rel_hit;
    logic                        c_move;
    logic                        stay;
    logic [KW-1:0]               fin_key;
    logic [KW+1:0]               key_ext;
    logic [KW+1:0]               fin_ext;
    out_word_t                   o_data_next;

    // compare (slow - fast) * 2^16 against both thresholds
    always_comb
    begin
        lvl_diff    = $signed({1'b0, c_levels_reg.slow}) - $signed({1'b0, c_levels_reg.fast});
        diff_scaled = $signed({lvl_diff[LEVEL_W], lvl_diff, FACTOR_W'(0)});
        press_thr   = press_factor * c_levels_reg.slow;
        rel_thr     = release_factor * c_levels_reg.slow;
        press_hit   = c_detect_reg && !latched_reg[c_key_reg]
                      && (diff_scaled > $signed({2'b00, press_thr}));
        rel_hit     = c_detect_reg && (diff_scaled < $signed({2'b00, rel_thr}));
    end

    // pointer decision and handshake toward the result register
    always_comb
    begin
        c_move  = c_valid_reg && (!o_valid_reg || m_axis_tready);
        stay    = c_valid_reg && press_hit;
        fin_key = stay ? c_key_reg : c_adv_reg;
        key_ext = {2'b00, c_key_reg};
        fin_ext = {2'b00, fin_key};

        o_data_next.pad         = '0;
        o_data_next.press_event = press_hit;
        o_data_next.pressed_key = press_hit ? key_ext[1:0] : 2'b00;
        o_data_next.next_key    = fin_ext[1:0];

        status.valid = c_valid_reg;
        status.stay  = stay;
        status.move  = c_move;
        status.ready = !c_valid_reg || c_move;
    end

    assign key           = c_key_reg;
    assign final_key     = fin_key;
    assign levels        = c_levels_reg;
    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tdata  = o_data_reg;

    // stage and result valid flags, latch bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
            latched_reg <= '0;
        end
        else
        begin
            if (load)
            begin
                c_valid_reg <= 1'b1;
            end
            else if (c_move)
            begin
                c_valid_reg <= 1'b0;
            end

            if (c_move)
            begin
                o_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                o_valid_reg <= 1'b0;
            end

            // latch on a fresh press, drop once below the release level
            if (c_move && c_detect_reg)
            begin
                if (press_hit)
                begin
                    latched_reg[c_key_reg] <= 1'b1;
                end
                else if (rel_hit)
                begin
                    latched_reg[c_key_reg] <= 1'b0;
                end
            end
        end
    end

    // stage payload and result word
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            c_key_reg    <= in_key;
            c_adv_reg    <= in_adv_key;
            c_levels_reg <= in_levels;
            c_detect_reg <= in_detect;
        end
        if (c_move)
        begin
            o_data_reg <= o_data_next;
        end
    end

    a_press_latches: assert property (@(posedge clk) disable iff (!rst_n)
        c_move && press_hit |=> latched_reg[$past(c_key_reg)])
        else $error("press did not latch its key");

    a_press_holds_pointer: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg && o_data_reg.press_event |-> o_data_reg.next_key == o_data_reg.pressed_key)
        else $error("pointer moved on a press word");

endmodule

FILE: rtl/cap_touch_key_detector.sv
// Top level of the round-robin capacitive touch key detector.
// Depends on ctkd_pkg, ctkd_ram, ctkd_filter and ctkd_detect.
//
// Usage:
//   Samples enter on the s_axis stream, one word per sample, taken for the key
//   that the previous result named as next_key (key 0 after reset). Each
//   sample gives exactly one result word on the m_axis stream: press_event,
//   pressed_key and next_key.
//   The cfg port writes one register per clock; the user must write only while the block is idle,
//   which the block does not enforce. Writing startup_count also reloads the startup counter.
// Throughput and pipeline:
//   One sample per clock while m_axis_tready stays high. The level memory is
//   read at the accepting edge, the update stage runs both IIR filters, the
//   decide stage runs the threshold multiplies and writes the levels back; a
//   press keeps the same key, so the update stage forwards the decide stage's
//   levels instead of memory.
// Reset:
//   Registers load their default values, all keys are marked unfilled and
//   unlatched, the pointer returns to key 0. The level memory is not cleared.
// Stall:
//   The result register holds while m_axis_tready is low; the two stages
//   behind it keep filling, so up to two more samples are taken meanwhile.
module cap_touch_key_detector
    import ctkd_pkg::*;
#(
    parameter int NUM_KEYS = 4
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,    // sample[9:0]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,    // press_event, pressed_key[1:0], next_key[1:0]
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    // configuration
    logic [COEFF_W-1:0]  slow_coeff_reg;
    logic [COEFF_W-1:0]  fast_coeff_reg;
    logic [FACTOR_W-1:0] press_factor_reg;
    logic [FACTOR_W-1:0] release_factor_reg;
    logic [COUNT_W-1:0]  startup_left_reg;

    // update stage and key bookkeeping
    logic                u_valid_reg;
    logic [SAMPLE_W-1:0] u_sample_reg;
    logic                u_byp_reg;
    level_pair_t         u_byp_data_reg;
    logic [KW-1:0]       ptr_reg;
    logic [NUM_KEYS-1:0] known_reg;

    det_status_t         dstat;
    logic [KW-1:0]       c_key;
    logic [KW-1:0]       c_final_key;
    level_pair_t         c_levels;
    level_pair_t         ram_rdata;
    level_pair_t         mem_word;
    level_pair_t         upd_stay;
    level_pair_t         upd_adv;
    level_pair_t         target_pair;
    level_pair_t         u_new;
    logic [KW-1:0]       u_key;
    logic [KW-1:0]       u_adv_key;
    logic [KW-1:0]       pred_key;
    logic                use_c;
    logic                u_known;
    logic                u_detect;
    logic                accept;
    logic                u_move;

    function automatic logic [KW-1:0] wrap_inc(input logic [KW-1:0] k);
        if (k == KW'(NUM_KEYS - 1))
        begin
            return '0;
        end
        return k + 1'b1;
    endfunction

    // handshake, key resolution and level selection for the update stage
    always_comb
    begin
        accept        = s_axis_tvalid && s_axis_tready;
        u_move        = u_valid_reg && dstat.ready;
        s_axis_tready = !u_valid_reg || dstat.ready;

        u_key     = dstat.valid ? c_final_key : ptr_reg;
        u_adv_key = wrap_inc(u_key);
        // read ahead for the key the next word takes unless a press holds it
        pred_key  = u_valid_reg ? u_adv_key : u_key;

        use_c    = dstat.valid && (c_final_key == c_key);
        mem_word = u_byp_reg ? u_byp_data_reg : ram_rdata;
        u_known  = known_reg[u_key];

        target_pair.slow = {u_sample_reg, FRAC_W'(0)};
        target_pair.fast = {u_sample_reg, FRAC_W'(0)};

        if (!u_known)
        begin
            u_new = target_pair;
        end
        else if (use_c)
        begin
            u_new = upd_stay;
        end
        else
        begin
            u_new = upd_adv;
        end

        u_detect = u_known && (startup_left_reg == '0);
    end

    // filter candidates: the decide stage's levels and the memory word
    ctkd_filter u_filt_stay (
        .levels     (c_levels),
        .sample     (u_sample_reg),
        .slow_coeff (slow_coeff_reg),
        .fast_coeff (fast_coeff_reg),
        .updated    (upd_stay)
    );

    ctkd_filter u_filt_adv (
        .levels     (mem_word),
        .sample     (u_sample_reg),
        .slow_coeff (slow_coeff_reg),
        .fast_coeff (fast_coeff_reg),
        .updated    (upd_adv)
    );

    ctkd_ram #(
        .WIDTH ($bits(level_pair_t)),
        .DEPTH (NUM_KEYS)
    ) u_level_ram (
        .clk   (clk),
        .we    (dstat.move),
        .waddr (c_key),
        .wdata (c_levels),
        .re    (accept),
        .raddr (pred_key),
        .rdata (ram_rdata)
    );

    ctkd_detect #(
        .NUM_KEYS (NUM_KEYS),
        .KW       (KW)
    ) u_detect_stage (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (u_move),
        .in_key         (u_key),
        .in_adv_key     (u_adv_key),
        .in_levels      (u_new),
        .in_detect      (u_detect),
        .press_factor   (press_factor_reg),
        .release_factor (release_factor_reg),
        .status         (dstat),
        .key            (c_key),
        .final_key      (c_final_key),
        .levels         (c_levels),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata)
    );

    // configuration, startup count, pointer and fill flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slow_coeff_reg     <= SLOW_COEFF_RST;
            fast_coeff_reg     <= FAST_COEFF_RST;
            press_factor_reg   <= PRESS_FACTOR_RST;
            release_factor_reg <= RELEASE_FACTOR_RST;
            startup_left_reg   <= STARTUP_COUNT_RST;
            u_valid_reg        <= 1'b0;
            u_byp_reg          <= 1'b0;
            ptr_reg            <= '0;
            known_reg          <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_SLOW_COEFF:     slow_coeff_reg     <= cfg_wdata[COEFF_W-1:0];
                    REG_FAST_COEFF:     fast_coeff_reg     <= cfg_wdata[COEFF_W-1:0];
                    REG_PRESS_FACTOR:   press_factor_reg   <= cfg_wdata[FACTOR_W-1:0];
                    REG_RELEASE_FACTOR: release_factor_reg <= cfg_wdata[FACTOR_W-1:0];
                    REG_STARTUP_COUNT:  startup_left_reg   <= cfg_wdata[COUNT_W-1:0];
                    default:            ;
                endcase
            end
            else if (u_move && u_known && (startup_left_reg != '0))
            begin
                startup_left_reg <= startup_left_reg - 1'b1;
            end

            if (accept)
            begin
                u_valid_reg <= 1'b1;
                // forward a write-back that hits the entry read this cycle
                u_byp_reg   <= dstat.move && (c_key == pred_key);
            end
            else if (u_move)
            begin
                u_valid_reg <= 1'b0;
            end

            if (u_move)
            begin
                known_reg[u_key] <= 1'b1;
            end

            if (dstat.move)
            begin
                ptr_reg <= c_final_key;
            end
        end
    end

    // update stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            u_sample_reg   <= s_axis_tdata[SAMPLE_W-1:0];
            u_byp_data_reg <= c_levels;
        end
    end

    a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= KW'(NUM_KEYS - 1))
        else $error("key pointer out of range");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> pred_key <= KW'(NUM_KEYS - 1))
        else $error("level memory read beyond last key");

    a_startup_no_rise: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_we |=> startup_left_reg <= $past(startup_left_reg))
        else $error("startup counter rose without a register write");

endmodule
